/* rtl/cct_pkg.sv */
// Shared types, constants and calendar functions for the real-time clock calendar.
// Used by cct_cell, calendar_clock_tick and the testbench; depends on nothing else.
package cct_pkg;

	localparam int SEC_W   = 6;
	localparam int MIN_W   = 6;
	localparam int HOUR_W  = 5;
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	localparam logic [SEC_W-1:0]   SEC_LAST    = 6'd59;
	localparam logic [MIN_W-1:0]   MIN_LAST    = 6'd59;
	localparam logic [HOUR_W-1:0]  HOUR_LAST   = 5'd23;
	localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd12;
	localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
	localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
	localparam logic [DAY_W-1:0]   DAY_LEAP    = 5'd29;
	localparam logic [DAY_W-1:0]   DAY_MAX     = 5'd31;
	localparam logic [MONTH_W-1:0] MONTH_FIRST = 4'd1;

	localparam logic [SEC_W-1:0]   SEC_RST   = 6'd0;
	localparam logic [MIN_W-1:0]   MIN_RST   = 6'd0;
	localparam logic [HOUR_W-1:0]  HOUR_RST  = 5'd0;
	localparam logic [DAY_W-1:0]   DAY_RST   = 5'd1;
	localparam logic [MONTH_W-1:0] MONTH_RST = 4'd1;
	localparam logic [YEAR_W-1:0]  YEAR_RST  = 14'd2000;

	// Reciprocal of 100 scaled by 2^19; exact quotient for every 14-bit year.
	localparam int          RECIP_SHIFT = 19;
	localparam logic [12:0] RECIP_100   = 13'd5243;

	localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef struct packed {
		logic               cmd;
		logic [SEC_W-1:0]   set_second;
		logic [MIN_W-1:0]   set_minute;
		logic [HOUR_W-1:0]  set_hour;
		logic [DAY_W-1:0]   set_day;
		logic [MONTH_W-1:0] set_month;
		logic [YEAR_W-1:0]  set_year;
	} req_t;

	typedef struct packed {
		logic [SEC_W-1:0]   cur_second;
		logic [MIN_W-1:0]   cur_minute;
		logic [HOUR_W-1:0]  cur_hour;
		logic [DAY_W-1:0]   cur_day;
		logic [MONTH_W-1:0] cur_month;
		logic [YEAR_W-1:0]  cur_year;
		logic               day_advanced;
		logic               load_rejected;
	} rsp_t;

	// Per-cell control: count one step, or overwrite with a load value.
	typedef struct packed {
		logic step;
		logic load;
	} cell_ctl_t;

	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [YEAR_W+12:0] prod;
		logic [7:0]         q;
		logic [YEAR_W-1:0]  q100;
		logic               div100;
		begin
			prod   = y * RECIP_100;
			q      = prod[RECIP_SHIFT+7:RECIP_SHIFT];
			// q * 100 as shift-and-add
			q100   = YEAR_W'({q, 6'd0}) + YEAR_W'({q, 5'd0}) + YEAR_W'({q, 2'd0});
			div100 = (q100 == y);
			is_leap = (y[1:0] == 2'd0) && (!div100 || (q[1:0] == 2'd0));
		end
	endfunction

	function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
		input logic [YEAR_W-1:0] y);
		logic [MONTH_W-1:0] idx;
		begin
			idx = m - MONTH_FIRST;
			if (m < MONTH_FIRST || m > MONTH_LAST) begin
				days_in = DAY_MAX;
			end else if (m == MONTH_FEB && is_leap(y)) begin
				days_in = DAY_LEAP;
			end else begin
				days_in = MONTH_LEN[idx];
			end
		end
	endfunction

endpackage

/* rtl/calendar_clock_tick.sv */
// Real-time clock with Gregorian calendar, built as a chain of counter cells.
// Depends on cct_pkg and cct_cell.
//
// Usage:
//   Request channel (req_valid, req_stall, req): each beat is a tick (advance
//   one second) or a load of the full date and time. A load with any field out
//   of range leaves the clock as it was and sets load_rejected.
//   Response channel (rsp_valid, rsp_stall, rsp): one beat per request, carrying
//   the date and time after that request plus the day_advanced and
//   load_rejected flags.
// Response path: the result is registered in the output register or the skid entry.
// Throughput: one request per cycle while req_stall is low; the seconds-to-year
//   carry runs combinationally through the cell chain in the cycle the request is
//   taken, with the month length looked up from the current month and year.
// Stall: a two-entry output (register plus skid) absorbs one beat while the
//   receiver stalls; req_stall rises only when both entries are full.
// Reset: clears both output entries and sets the clock to 00:00:00 on
//   day 1, month 1, year 2000.
module calendar_clock_tick
	import cct_pkg::*;
#(
	parameter int LAST_YEAR = 9999
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam logic [YEAR_W-1:0] LAST_YEAR_V = YEAR_W'(LAST_YEAR);

	logic accept, tick, load_ok, load;
	logic sec_c, min_c, hour_c, day_c, month_c, year_c;

	logic [SEC_W-1:0]   sec_v,   sec_n;
	logic [MIN_W-1:0]   min_v,   min_n;
	logic [HOUR_W-1:0]  hour_v,  hour_n;
	logic [DAY_W-1:0]   day_v,   day_n;
	logic [MONTH_W-1:0] month_v, month_n;
	logic [YEAR_W-1:0]  year_v,  year_n;
	logic [DAY_W-1:0]   cur_len;

	cell_ctl_t sec_ctl, min_ctl, hour_ctl, day_ctl, month_ctl, year_ctl;

	rsp_t result;
	rsp_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;
	logic out_take;

	assign req_stall = skid_valid_q;
	assign accept    = req_valid && !skid_valid_q;
	assign tick      = accept && (req.cmd == CMD_TICK);

	assign load_ok = (req.set_second <= SEC_LAST) && (req.set_minute <= MIN_LAST) &&
		(req.set_hour <= HOUR_LAST) && (req.set_month >= MONTH_FIRST) &&
		(req.set_month <= MONTH_LAST) && (req.set_year <= LAST_YEAR_V) &&
		(req.set_day >= DAY_FIRST) && (req.set_day <= days_in(req.set_month, req.set_year));
	assign load = accept && (req.cmd == CMD_LOAD) && load_ok;

	assign cur_len = days_in(month_v, year_v);

	assign sec_ctl   = '{step: tick,   load: load};
	assign min_ctl   = '{step: sec_c,  load: load};
	assign hour_ctl  = '{step: min_c,  load: load};
	assign day_ctl   = '{step: hour_c, load: load};
	assign month_ctl = '{step: day_c,  load: load};
	assign year_ctl  = '{step: month_c, load: load};

	cct_cell #(.W(SEC_W), .RST_VAL(SEC_RST)) u_sec (
		.clk(clk), .arst_n(arst_n), .ctl(sec_ctl), .first('0), .last(SEC_LAST),
		.load_val(req.set_second), .value(sec_v), .nxt(sec_n), .carry(sec_c)
	);

	cct_cell #(.W(MIN_W), .RST_VAL(MIN_RST)) u_min (
		.clk(clk), .arst_n(arst_n), .ctl(min_ctl), .first('0), .last(MIN_LAST),
		.load_val(req.set_minute), .value(min_v), .nxt(min_n), .carry(min_c)
	);

	cct_cell #(.W(HOUR_W), .RST_VAL(HOUR_RST)) u_hour (
		.clk(clk), .arst_n(arst_n), .ctl(hour_ctl), .first('0), .last(HOUR_LAST),
		.load_val(req.set_hour), .value(hour_v), .nxt(hour_n), .carry(hour_c)
	);

	cct_cell #(.W(DAY_W), .RST_VAL(DAY_RST)) u_day (
		.clk(clk), .arst_n(arst_n), .ctl(day_ctl), .first(DAY_FIRST), .last(cur_len),
		.load_val(req.set_day), .value(day_v), .nxt(day_n), .carry(day_c)
	);

	cct_cell #(.W(MONTH_W), .RST_VAL(MONTH_RST)) u_month (
		.clk(clk), .arst_n(arst_n), .ctl(month_ctl), .first(MONTH_FIRST),
		.last(MONTH_LAST), .load_val(req.set_month), .value(month_v), .nxt(month_n),
		.carry(month_c)
	);

	cct_cell #(.W(YEAR_W), .RST_VAL(YEAR_RST)) u_year (
		.clk(clk), .arst_n(arst_n), .ctl(year_ctl), .first('0), .last(LAST_YEAR_V),
		.load_val(req.set_year), .value(year_v), .nxt(year_n), .carry(year_c)
	);

	always_comb begin
		result.cur_second    = sec_n;
		result.cur_minute    = min_n;
		result.cur_hour      = hour_n;
		result.cur_day       = day_n;
		result.cur_month     = month_n;
		// year wrap carry is only informative; the cell already wrapped
		result.cur_year      = year_n;
		result.day_advanced  = hour_c;
		result.load_rejected = accept && (req.cmd == CMD_LOAD) && !load_ok;
	end

	assign out_take  = out_valid_q && !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_take) begin
				// drain the skid first, else take the new beat
				out_valid_q  <= skid_valid_q || accept;
				skid_valid_q <= 1'b0;
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			out_q <= skid_valid_q ? skid_q : result;
		end else if (accept) begin
			skid_q <= result;
		end
	end

`ifndef SYNTHESIS
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held with empty output register");

	a_reject_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.cmd == CMD_LOAD && !load_ok) |=>
		($stable(sec_v) && $stable(min_v) && $stable(hour_v) &&
		$stable(day_v) && $stable(month_v) && $stable(year_v)))
		else $error("rejected load changed the clock");

	a_advance_at_midnight: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.day_advanced) |->
		(rsp.cur_second == '0 && rsp.cur_minute == '0 && rsp.cur_hour == '0))
		else $error("date advanced away from midnight");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.day_advanced && rsp.load_rejected))
		else $error("both result flags set");

	a_year_carry_on_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		year_c |=> (year_v == '0))
		else $error("year rollover did not wrap to zero");
`endif

endmodule

/* rtl/cct_cell.sv */
// One counter cell of the clock chain: holds one field, loads it, or steps on carry-in and wraps.
// Depends on cct_pkg for the cell control struct.
module cct_cell
	import cct_pkg::*;
#(
	parameter int               W       = 6,
	parameter logic [W-1:0]     RST_VAL = '0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cell_ctl_t       ctl,
	input  logic [W-1:0]    first,
	input  logic [W-1:0]    last,
	input  logic [W-1:0]    load_val,
	output logic [W-1:0]    value,
	output logic [W-1:0]    nxt,
	output logic            carry
);

	logic [W-1:0] value_q;
	logic         at_end;

	assign at_end = (value_q >= last);
	assign carry  = ctl.step && at_end;
	assign value  = value_q;

	always_comb begin
		nxt = value_q;
		if (ctl.load) begin
			nxt = load_val;
		end else if (ctl.step) begin
			nxt = at_end ? first : value_q + W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= RST_VAL;
		end else begin
			value_q <= nxt;
		end
	end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for calendar_clock_tick: drives tick and load beats,
// predicts each response in a behavioral calendar model and compares field by field.
// Depends on cct_pkg and the calendar_clock_tick RTL.
module testbench
	import cct_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LAST_YEAR = 9999;
	localparam int IDLE_LIMIT = 600;
	localparam int RSP_HOLD_CYCLES = 50;
	localparam int YEAR_ALL_ONES = (1 << YEAR_W) - 1;
	localparam int NOTABLE_YEARS [10] = '{0, 100, 400, 1900, 2000, 2023, 2024, 2100, 2400, 9996};

	typedef struct packed {
		logic [SEC_W-1:0]   sec;
		logic [MIN_W-1:0]   min;
		logic [HOUR_W-1:0]  hour;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} cal_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	cal_state_t cal;
	rsp_t expected_times [$];
	int mismatch_count = 0;
	int req_gap_max = 19;
	int rsp_stall_max = 19;
	int rsp_hold_request = 0;

	calendar_clock_tick #(
		.LAST_YEAR(LAST_YEAR)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	function automatic int draw_wait(input int max_cycles);
		return (max_cycles == 0) ? 0 : $urandom_range(0, max_cycles);
	endfunction

	function automatic logic leap_year(input logic [YEAR_W-1:0] y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
		input logic [YEAR_W-1:0] y);
		case (m)
			4'd2: return leap_year(y) ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
			default: return 5'd31;
		endcase
	endfunction

	// Apply one accepted beat to the calendar copy and return the response it causes.
	function automatic rsp_t advance_calendar(input req_t it);
		rsp_t res;
		logic rolled;
		logic bad;
		rolled = 1'b0;
		bad = 1'b0;
		if (it.cmd == CMD_TICK) begin
			if (cal.sec >= SEC_LAST) begin
				cal.sec = '0;
				if (cal.min >= MIN_LAST) begin
					cal.min = '0;
					if (cal.hour >= HOUR_LAST) begin
						cal.hour = '0;
						rolled = 1'b1;
					end else begin
						cal.hour = cal.hour + 1'b1;
					end
				end else begin
					cal.min = cal.min + 1'b1;
				end
			end else begin
				cal.sec = cal.sec + 1'b1;
			end
			if (rolled) begin
				if (cal.day < month_days(cal.month, cal.year)) begin
					cal.day = cal.day + 1'b1;
				end else if (cal.month >= MONTH_LAST) begin
					cal.day = DAY_FIRST;
					cal.month = MONTH_FIRST;
					cal.year = (cal.year >= LAST_YEAR) ? '0 : cal.year + 1'b1;
				end else begin
					cal.day = DAY_FIRST;
					cal.month = cal.month + 1'b1;
				end
			end
		end else begin
			bad = it.set_second > SEC_LAST || it.set_minute > MIN_LAST ||
				it.set_hour > HOUR_LAST || it.set_month < MONTH_FIRST ||
				it.set_month > MONTH_LAST || it.set_year > LAST_YEAR ||
				it.set_day < DAY_FIRST || it.set_day > month_days(it.set_month, it.set_year);
			if (!bad) begin
				cal.sec = it.set_second;
				cal.min = it.set_minute;
				cal.hour = it.set_hour;
				cal.day = it.set_day;
				cal.month = it.set_month;
				cal.year = it.set_year;
			end
		end
		res.cur_second = cal.sec;
		res.cur_minute = cal.min;
		res.cur_hour = cal.hour;
		res.cur_day = cal.day;
		res.cur_month = cal.month;
		res.cur_year = cal.year;
		res.day_advanced = rolled;
		res.load_rejected = bad;
		return res;
	endfunction

	function automatic req_t make_load(input int s, input int mi, input int h, input int d,
		input int mo, input int y);
		req_t it;
		it.cmd = CMD_LOAD;
		it.set_second = SEC_W'(s);
		it.set_minute = MIN_W'(mi);
		it.set_hour = HOUR_W'(h);
		it.set_day = DAY_W'(d);
		it.set_month = MONTH_W'(mo);
		it.set_year = YEAR_W'(y);
		return it;
	endfunction

	function automatic req_t random_item(input logic cmd);
		logic [63:0] raw;
		req_t it;
		raw = {$urandom, $urandom};
		it = raw[$bits(req_t)-1:0];
		it.cmd = cmd;
		return it;
	endfunction

	function automatic logic [YEAR_W-1:0] pick_year();
		case ($urandom_range(0, 3))
			0: return YEAR_W'(LAST_YEAR);
			1, 2: return YEAR_W'(NOTABLE_YEARS[$urandom_range(0, 9)]);
			default: return YEAR_W'($urandom_range(0, LAST_YEAR));
		endcase
	endfunction

	// Valid load, biased toward the last seconds of a day at the end of a month.
	function automatic req_t near_rollover_load();
		req_t it;
		logic [DAY_W-1:0] len;
		it = '0;
		it.cmd = CMD_LOAD;
		it.set_year = pick_year();
		it.set_month = ($urandom_range(0, 3) == 0) ? MONTH_LAST : MONTH_W'($urandom_range(1, 12));
		len = month_days(it.set_month, it.set_year);
		it.set_day = $urandom_range(0, 1) ? len : DAY_W'($urandom_range(1, len));
		if ($urandom_range(0, 1)) begin
			it.set_hour = HOUR_LAST;
			it.set_minute = MIN_LAST;
			it.set_second = SEC_W'($urandom_range(52, 59));
		end else begin
			it.set_hour = HOUR_W'($urandom_range(0, 23));
			it.set_minute = MIN_W'($urandom_range(0, 59));
			it.set_second = SEC_W'($urandom_range(0, 59));
		end
		return it;
	endfunction

	// Break exactly one field of an otherwise valid load.
	function automatic req_t corrupt_load(input req_t it);
		logic [DAY_W-1:0] len;
		len = month_days(it.set_month, it.set_year);
		case ($urandom_range(0, 5))
			0: it.set_second = SEC_W'($urandom_range(60, 63));
			1: it.set_minute = MIN_W'($urandom_range(60, 63));
			2: it.set_hour = HOUR_W'($urandom_range(24, 31));
			3: it.set_day = (len == DAY_MAX || $urandom_range(0, 1)) ? '0 :
				DAY_W'($urandom_range(len + 1, 31));
			4: it.set_month = $urandom_range(0, 1) ? '0 : MONTH_W'($urandom_range(13, 15));
			default: it.set_year = YEAR_W'($urandom_range(LAST_YEAR + 1, YEAR_ALL_ONES));
		endcase
		return it;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Offer one beat after a random gap; valid stays high if the gap is zero.
	task automatic send_item(input req_t it);
		int gap;
		gap = draw_wait(req_gap_max);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (req_stall);
		expected_times.push_back(advance_calendar(it));
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (expected_times.size() != 0) @(posedge clk);
	endtask

	task automatic test_reset_and_wrap();
		send_item(random_item(CMD_TICK));
		send_item(make_load(59, 59, 23, 31, 12, LAST_YEAR));
		send_item(random_item(CMD_TICK));
		send_item(make_load(0, 0, 0, 1, 1, 0));
		send_item(make_load(59, 59, 10, 15, 6, 2023));
		send_item(random_item(CMD_TICK));
	endtask

	task automatic test_leap_years();
		send_item(make_load(59, 59, 23, 28, 2, 2000));
		send_item(random_item(CMD_TICK));
		send_item(make_load(59, 59, 23, 29, 2, 1900));
		send_item(make_load(59, 59, 23, 28, 2, 1900));
		send_item(random_item(CMD_TICK));
		send_item(make_load(59, 59, 23, 28, 2, 2024));
		send_item(random_item(CMD_TICK));
	endtask

	task automatic test_month_ends();
		send_item(make_load(59, 59, 23, 30, 4, 2023));
		send_item(random_item(CMD_TICK));
		send_item(make_load(59, 59, 23, 29, 2, 2024));
		send_item(random_item(CMD_TICK));
	endtask

	task automatic test_rejected_loads();
		send_item(make_load(60, 0, 0, 1, 1, 2000));
		send_item(make_load(0, 63, 0, 1, 1, 2000));
		send_item(make_load(0, 0, 24, 1, 1, 2000));
		send_item(make_load(0, 0, 0, 0, 1, 2000));
		send_item(make_load(0, 0, 0, 31, 4, 2000));
		send_item(make_load(0, 0, 0, 1, 0, 2000));
		send_item(make_load(0, 0, 0, 1, 15, 2000));
		send_item(make_load(0, 0, 0, 1, 1, LAST_YEAR + 1));
		send_item(make_load(63, 63, 31, 31, 15, YEAR_ALL_ONES));
		// set fields are don't-care on a tick
		send_item(make_load(63, 63, 31, 31, 15, YEAR_ALL_ONES) ^ {1'b1, 40'd0});
	endtask

	// Mostly a valid load and a run of ticks; else noise, a bad load or ticks alone.
	task automatic test_random_traffic(input int n_items, input int gap_max, input int stall_max);
		int sent;
		int kind;
		int run;
		req_gap_max = gap_max;
		rsp_stall_max = stall_max;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				send_item(near_rollover_load());
				run = $urandom_range(1, 8);
				sent++;
			end else if (kind == 6) begin
				send_item(random_item(CMD_LOAD));
				run = $urandom_range(0, 3);
				sent++;
			end else if (kind == 7) begin
				send_item(corrupt_load(near_rollover_load()));
				run = $urandom_range(0, 3);
				sent++;
			end else begin
				run = $urandom_range(1, 12);
			end
			repeat (run) send_item(random_item(CMD_TICK));
			sent += run;
		end
	endtask

	// Hold the response side off while beats keep coming, so the input stalls.
	task automatic test_output_backpressure();
		req_gap_max = 0;
		rsp_hold_request = RSP_HOLD_CYCLES;
		repeat (30) send_item(random_item(CMD_TICK));
	endtask

	task automatic test_idle_between_bursts();
		drain_results();
		test_random_traffic(40, 0, 0);
	endtask

	initial begin : rsp_pacer
		int stall_left = 0;
		int hold_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_hold_request > 0) begin
				hold_left = rsp_hold_request;
				rsp_hold_request = 0;
			end
			if (rsp_valid && !rsp_stall) stall_left = draw_wait(rsp_stall_max);
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin : rsp_checker
		rsp_t want;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				if (expected_times.size() == 0) begin
					$error("response beat with no request outstanding");
					mismatch_count++;
				end else begin
					want = expected_times.pop_front();
					check_field("cur_second", want.cur_second, rsp.cur_second);
					check_field("cur_minute", want.cur_minute, rsp.cur_minute);
					check_field("cur_hour", want.cur_hour, rsp.cur_hour);
					check_field("cur_day", want.cur_day, rsp.cur_day);
					check_field("cur_month", want.cur_month, rsp.cur_month);
					check_field("cur_year", want.cur_year, rsp.cur_year);
					check_field("day_advanced", want.day_advanced, rsp.day_advanced);
					check_field("load_rejected", want.load_rejected, rsp.load_rejected);
				end
			end
		end
	end

	initial begin : watchdog
		int quiet_cycles = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		cal.sec = SEC_RST;
		cal.min = MIN_RST;
		cal.hour = HOUR_RST;
		cal.day = DAY_RST;
		cal.month = MONTH_RST;
		cal.year = YEAR_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_and_wrap();
		test_leap_years();
		test_month_ends();
		test_rejected_loads();
		test_random_traffic(300, 19, 19);
		test_output_backpressure();
		test_random_traffic(300, 0, 0);
		test_idle_between_bursts();
		test_random_traffic(300, 19, 0);
		test_random_traffic(300, 0, 19);
		drain_results();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/cct_pkg.sv
rtl/cct_cell.sv
rtl/calendar_clock_tick.sv
sim/testbench.sv
